/* hw/rtl/mpsd_pkg.sv */
// types and constants shared by the pot scanner and its checker
package mpsd_pkg;

   localparam int unsigned NOW_W    = 32;
   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned CHAN_W   = 3;
   localparam int unsigned SETTLE_W = 8;
   localparam int unsigned DBAND_W  = 16;
   localparam int unsigned PADDR_W  = 3;
   localparam int unsigned PDATA_W  = 32;

   localparam logic [SETTLE_W-1:0] SETTLE_RESET = 8'd1;
   localparam logic [DBAND_W-1:0]  DBAND_RESET  = 16'd768;

   typedef enum logic [1:0] {
      PH_SELECT  = 2'd0,
      PH_SETTLE  = 2'd1,
      PH_DUMMY   = 2'd2,
      PH_CONVERT = 2'd3
   } phase_type;

   typedef enum logic {
      REG_SETTLE_TIME = 1'b0,
      REG_DEADBAND    = 1'b1
   } reg_sel_type;

endpackage

/* hw/rtl/mux_pot_scanner_deadband.sv */
// multiplexed pot scanner with select/settle/dummy/convert phases and deadband filter
// an accepted item passes through the input register and then the result register
// throughput: one item per cycle while results are taken; the phase update is a single compare and subtract
// a stalled result holds the result register while the input register takes one more item
// reset (synchronous, active high): select phase, channel 0, all values and valid bits zero,
// settle time 1 ms, deadband 768
module mux_pot_scanner_deadband #(
   parameter int unsigned CHANNEL_COUNT = 6
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [mpsd_pkg::NOW_W-1:0]        req_now_ms,
   input  logic                              req_start_accepted,
   input  logic                              req_conversion_done,
   input  logic [mpsd_pkg::SAMPLE_W-1:0]     req_sample_raw,
   input  logic [mpsd_pkg::CHAN_W-1:0]       req_query_channel,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [mpsd_pkg::CHAN_W-1:0]       rsp_mux_channel,
   output logic                              rsp_mux_select_strobe,
   output logic                              rsp_start_request,
   output logic                              rsp_stop_request,
   output logic [1:0]                        rsp_scan_phase,
   output logic [mpsd_pkg::SAMPLE_W-1:0]     rsp_query_value,
   output logic                              rsp_query_valid,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [mpsd_pkg::PADDR_W-1:0]      paddr,
   input  logic [mpsd_pkg::PDATA_W-1:0]      pwdata,
   output logic [mpsd_pkg::PDATA_W-1:0]      prdata,
   output logic                              pready
);
   import mpsd_pkg::*;

   localparam logic [CHAN_W:0] CHAN_COUNT = (CHAN_W+1)'(CHANNEL_COUNT);

   // configuration
   logic [SETTLE_W-1:0] settle_ff;
   logic [DBAND_W-1:0]  dband_ff;
   reg_sel_type         reg_sel;
   logic                csr_write;

   assign pready    = 1'b1;
   assign reg_sel   = reg_sel_type'(paddr[2]);
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= SETTLE_RESET;
         dband_ff  <= DBAND_RESET;
      end else if (csr_write) begin
         unique case (reg_sel)
            REG_SETTLE_TIME: settle_ff <= pwdata[SETTLE_W-1:0];
            REG_DEADBAND:    dband_ff  <= pwdata[DBAND_W-1:0];
            default:         settle_ff <= settle_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_SETTLE_TIME: prdata = PDATA_W'(settle_ff);
         REG_DEADBAND:    prdata = PDATA_W'(dband_ff);
         default:         prdata = '0;
      endcase
   end

   // input register
   logic                s1_valid_ff;
   logic                s1_valid_in;
   logic [NOW_W-1:0]    s1_now_ff;
   logic                s1_acc_ff;
   logic                s1_done_ff;
   logic [SAMPLE_W-1:0] s1_raw_ff;
   logic [CHAN_W-1:0]   s1_query_ff;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                advance;
   logic                fire;
   logic                req_take;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign fire      = s1_valid_ff && advance;
   assign req_ready = !s1_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (fire) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_now_ff   <= req_now_ms;
         s1_acc_ff   <= req_start_accepted;
         s1_done_ff  <= req_conversion_done;
         s1_raw_ff   <= req_sample_raw;
         s1_query_ff <= req_query_channel;
      end
   end

   // scan state
   phase_type           phase_ff, phase_in;
   logic [CHAN_W-1:0]   active_ff, active_in;
   logic [NOW_W-1:0]    settle_start_ff, settle_start_in;
   logic [SAMPLE_W-1:0] values_ff [CHANNEL_COUNT];
   logic [SAMPLE_W-1:0] values_in [CHANNEL_COUNT];
   logic [CHANNEL_COUNT-1:0] valid_bits_ff, valid_bits_in;

   logic [NOW_W-1:0]    elapsed;
   logic                settle_over;
   logic [CHAN_W-1:0]   ch_eff;
   logic [CHAN_W:0]     ch_plus;
   logic [CHAN_W-1:0]   ch_next;
   logic [SAMPLE_W-1:0] sample_val;
   logic [SAMPLE_W-1:0] old_val;
   logic                was_valid;
   logic [SAMPLE_W:0]   diff_raw;
   logic [SAMPLE_W-1:0] diff_abs;
   logic                replace;

   assign elapsed     = s1_now_ff - settle_start_ff;
   assign settle_over = elapsed >= NOW_W'(settle_ff);
   assign ch_eff      = ({1'b0, active_ff} >= CHAN_COUNT) ? '0 : active_ff;
   assign ch_plus     = {1'b0, ch_eff} + (CHAN_W+1)'(1);
   assign ch_next     = (ch_plus >= CHAN_COUNT) ? '0 : ch_plus[CHAN_W-1:0];
   assign sample_val  = ~s1_raw_ff;

   always_comb begin
      old_val   = '0;
      was_valid = 1'b0;
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
         if (ch_eff == CHAN_W'(i)) begin
            old_val   = values_ff[i];
            was_valid = valid_bits_ff[i];
         end
      end
   end

   assign diff_raw = {1'b0, sample_val} - {1'b0, old_val};
   assign diff_abs = diff_raw[SAMPLE_W] ? (old_val - sample_val) : diff_raw[SAMPLE_W-1:0];
   assign replace  = ((diff_abs != '0) && (diff_abs >= dband_ff)) || !was_valid;

   // next state
   always_comb begin
      phase_in        = phase_ff;
      active_in       = active_ff;
      settle_start_in = settle_start_ff;
      values_in       = values_ff;
      valid_bits_in   = valid_bits_ff;
      if (fire) begin
         unique case (phase_ff)
            PH_SELECT: begin
               settle_start_in = s1_now_ff;
               phase_in        = PH_SETTLE;
            end
            PH_SETTLE: begin
               if (settle_over && s1_acc_ff) begin
                  phase_in = PH_DUMMY;
               end
            end
            PH_DUMMY: begin
               if (s1_done_ff) begin
                  phase_in = s1_acc_ff ? PH_CONVERT : PH_SELECT;
               end
            end
            PH_CONVERT: begin
               if (s1_done_ff) begin
                  for (int i = 0; i < CHANNEL_COUNT; i++) begin
                     if (ch_eff == CHAN_W'(i)) begin
                        if (replace) begin
                           values_in[i] = sample_val;
                        end
                        valid_bits_in[i] = 1'b1;
                     end
                  end
                  active_in = ch_next;
                  phase_in  = PH_SELECT;
               end
            end
            default: phase_in = PH_SELECT;
         endcase
      end
   end

   // strobes
   logic sel_strobe;
   logic start_req;
   logic stop_req;

   always_comb begin
      sel_strobe = 1'b0;
      start_req  = 1'b0;
      stop_req   = 1'b0;
      unique case (phase_ff)
         PH_SELECT:  sel_strobe = 1'b1;
         PH_SETTLE:  start_req  = settle_over;
         PH_DUMMY: begin
            start_req = s1_done_ff;
            stop_req  = s1_done_ff;
         end
         PH_CONVERT: stop_req   = s1_done_ff;
         default:    sel_strobe = 1'b0;
      endcase
   end

   logic [SAMPLE_W-1:0] q_value;
   logic                q_valid;

   always_comb begin
      q_value = '0;
      q_valid = 1'b0;
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
         if (s1_query_ff == CHAN_W'(i)) begin
            q_value = values_in[i];
            q_valid = valid_bits_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_SELECT;
         active_ff       <= '0;
         settle_start_ff <= '0;
         valid_bits_ff   <= '0;
         for (int i = 0; i < CHANNEL_COUNT; i++) begin
            values_ff[i] <= '0;
         end
      end else begin
         phase_ff        <= phase_in;
         active_ff       <= active_in;
         settle_start_ff <= settle_start_in;
         valid_bits_ff   <= valid_bits_in;
         values_ff       <= values_in;
      end
   end

   // result register
   logic [CHAN_W-1:0]   out_chan_ff;
   logic                out_sel_ff;
   logic                out_start_ff;
   logic                out_stop_ff;
   logic [1:0]          out_phase_ff;
   logic [SAMPLE_W-1:0] out_qval_ff;
   logic                out_qvalid_ff;

   always_ff @(posedge clock) begin
      if (fire) begin
         out_chan_ff   <= active_in;
         out_sel_ff    <= sel_strobe;
         out_start_ff  <= start_req;
         out_stop_ff   <= stop_req;
         out_phase_ff  <= phase_in;
         out_qval_ff   <= q_value;
         out_qvalid_ff <= q_valid;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_mux_channel       = out_chan_ff;
   assign rsp_mux_select_strobe = out_sel_ff;
   assign rsp_start_request     = out_start_ff;
   assign rsp_stop_request      = out_stop_ff;
   assign rsp_scan_phase        = out_phase_ff;
   assign rsp_query_value       = out_qval_ff;
   assign rsp_query_valid       = out_qvalid_ff;

endmodule

/* hw/rtl/mpsd_checker.sv */
// port-level checks for the pot scanner, bound to the top level
module mpsd_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [mpsd_pkg::CHAN_W-1:0]   rsp_mux_channel,
   input logic                          rsp_mux_select_strobe,
   input logic                          rsp_start_request,
   input logic                          rsp_stop_request,
   input logic [1:0]                    rsp_scan_phase,
   input logic [mpsd_pkg::SAMPLE_W-1:0] rsp_query_value,
   input logic                          rsp_query_valid
);
   import mpsd_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mux_channel)
         && $stable(rsp_scan_phase) && $stable(rsp_query_value))
      else $error("result item changed while stalled");

   a_select_to_settle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mux_select_strobe |-> rsp_scan_phase == PH_SETTLE
         && !rsp_start_request && !rsp_stop_request)
      else $error("select item did not move to settle");

   a_stop_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stop_request |-> rsp_scan_phase == PH_SELECT
         || rsp_scan_phase == PH_CONVERT)
      else $error("stop item left a bad phase");

   a_start_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_start_request && !rsp_stop_request |-> rsp_scan_phase == PH_SETTLE
         || rsp_scan_phase == PH_DUMMY)
      else $error("start item left a bad phase");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind mux_pot_scanner_deadband mpsd_checker u_mpsd_checker (.*);

/* test/mpsd_checker.sv */
// checker for the pot scanner: predicts every scan report and compares it with the block output
module mpsd_scoreboard #(
   parameter int unsigned CHANNEL_COUNT = 6
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic [mpsd_pkg::NOW_W-1:0]        req_now_ms,
   input  logic                              req_start_accepted,
   input  logic                              req_conversion_done,
   input  logic [mpsd_pkg::SAMPLE_W-1:0]     req_sample_raw,
   input  logic [mpsd_pkg::CHAN_W-1:0]       req_query_channel,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [mpsd_pkg::CHAN_W-1:0]       rsp_mux_channel,
   input  logic                              rsp_mux_select_strobe,
   input  logic                              rsp_start_request,
   input  logic                              rsp_stop_request,
   input  logic [1:0]                        rsp_scan_phase,
   input  logic [mpsd_pkg::SAMPLE_W-1:0]     rsp_query_value,
   input  logic                              rsp_query_valid,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [mpsd_pkg::PADDR_W-1:0]      paddr,
   input  logic [mpsd_pkg::PDATA_W-1:0]      pwdata,
   input  logic                              pready,
   output int                                mismatch_count,
   output int                                reports_waiting
);
   timeunit 1ns;
   timeprecision 1ps;
   import mpsd_pkg::*;

   typedef struct {
      logic [CHAN_W-1:0]   mux_channel;
      logic                select_strobe;
      logic                start_req;
      logic                stop_req;
      phase_type           phase;
      logic [SAMPLE_W-1:0] query_value;
      logic                query_valid;
   } scan_report_type;

   phase_type             scan_phase;
   logic [CHAN_W-1:0]     pot_sel;
   logic [NOW_W-1:0]      settle_mark;
   logic [SAMPLE_W-1:0]   pot_level [CHANNEL_COUNT];
   logic [CHANNEL_COUNT-1:0] pot_seen;
   logic [SETTLE_W-1:0]   settle_ms;
   logic [DBAND_W-1:0]    dband;
   scan_report_type       scan_reports [$];

   task automatic advance_scan(input logic [NOW_W-1:0] now, input logic acc, input logic done,
                               input logic [SAMPLE_W-1:0] raw, input logic [CHAN_W-1:0] q,
                               output scan_report_type rep);
      logic [NOW_W-1:0]    elapsed;
      logic [SAMPLE_W-1:0] level;
      logic [SAMPLE_W-1:0] diff;
      rep.select_strobe = 1'b0;
      rep.start_req     = 1'b0;
      rep.stop_req      = 1'b0;
      rep.query_value   = '0;
      rep.query_valid   = 1'b0;
      case (scan_phase)
         PH_SELECT: begin
            rep.select_strobe = 1'b1;
            settle_mark = now;
            scan_phase = PH_SETTLE;
         end
         PH_SETTLE: begin
            elapsed = now - settle_mark;
            if (elapsed >= {{(NOW_W-SETTLE_W){1'b0}}, settle_ms}) begin
               rep.start_req = 1'b1;
               if (acc) scan_phase = PH_DUMMY;
            end
         end
         PH_DUMMY: begin
            if (done) begin
               rep.stop_req  = 1'b1;
               rep.start_req = 1'b1;
               scan_phase = acc ? PH_CONVERT : PH_SELECT;
            end
         end
         default: begin
            if (done) begin
               level = ~raw;
               diff = (level > pot_level[pot_sel]) ? level - pot_level[pot_sel]
                                                   : pot_level[pot_sel] - level;
               if ((diff != 0 && diff >= dband) || !pot_seen[pot_sel])
                  pot_level[pot_sel] = level;
               pot_seen[pot_sel] = 1'b1;
               pot_sel = (int'(pot_sel) + 1 >= CHANNEL_COUNT) ? '0 : pot_sel + 1'b1;
               rep.stop_req = 1'b1;
               scan_phase = PH_SELECT;
            end
         end
      endcase
      if (q < CHANNEL_COUNT) begin
         rep.query_value = pot_level[q];
         rep.query_valid = pot_seen[q];
      end
      rep.mux_channel = pot_sel;
      rep.phase       = scan_phase;
   endtask

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : monitor
      scan_report_type want;
      if (reset) begin
         scan_phase  = PH_SELECT;
         pot_sel     = '0;
         settle_mark = '0;
         pot_seen    = '0;
         for (int i = 0; i < CHANNEL_COUNT; i++) pot_level[i] = '0;
         settle_ms   = SETTLE_RESET;
         dband       = DBAND_RESET;
         scan_reports.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (scan_reports.size() == 0) begin
               $display("%0t ns: report with no item waiting, mux 0x%0h phase 0x%0h",
                        $time, rsp_mux_channel, rsp_scan_phase);
               mismatch_count++;
            end else begin
               want = scan_reports.pop_front();
               check_field("mux_channel", want.mux_channel, rsp_mux_channel);
               check_field("mux_select_strobe", want.select_strobe, rsp_mux_select_strobe);
               check_field("start_request", want.start_req, rsp_start_request);
               check_field("stop_request", want.stop_req, rsp_stop_request);
               check_field("scan_phase", want.phase, rsp_scan_phase);
               check_field("query_value", want.query_value, rsp_query_value);
               check_field("query_valid", want.query_valid, rsp_query_valid);
            end
         end
         if (req_valid && req_ready) begin
            advance_scan(req_now_ms, req_start_accepted, req_conversion_done,
                         req_sample_raw, req_query_channel, want);
            scan_reports.push_back(want);
         end
         if (psel && penable && pwrite && pready) begin
            case (reg_sel_type'(paddr[2]))
               REG_SETTLE_TIME: settle_ms = pwdata[SETTLE_W-1:0];
               REG_DEADBAND:    dband     = pwdata[DBAND_W-1:0];
            endcase
         end
      end
      reports_waiting = scan_reports.size();
   end

endmodule

/* test/tb_top.sv */
// top of the pot scanner testbench: clock, reset, scan item stimulus and verdict
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import mpsd_pkg::*;

   localparam int unsigned CHANNELS        = 6;
   localparam int unsigned ITEMS_PER_PHASE = 250;
   localparam int unsigned PHASES          = 6;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [NOW_W-1:0]    req_now_ms = '0;
   logic                req_start_accepted = 1'b0;
   logic                req_conversion_done = 1'b0;
   logic [SAMPLE_W-1:0] req_sample_raw = '0;
   logic [CHAN_W-1:0]   req_query_channel = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [CHAN_W-1:0]   rsp_mux_channel;
   logic                rsp_mux_select_strobe;
   logic                rsp_start_request;
   logic                rsp_stop_request;
   logic [1:0]          rsp_scan_phase;
   logic [SAMPLE_W-1:0] rsp_query_value;
   logic                rsp_query_valid;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [PADDR_W-1:0]  paddr = '0;
   logic [PDATA_W-1:0]  pwdata = '0;
   logic [PDATA_W-1:0]  prdata;
   logic                pready;

   int                  mismatch_count;
   int                  reports_waiting;
   int                  send_idle = 0;
   int                  recv_idle = 0;
   bit                  hold_rx = 1'b0;
   int                  items_sent = 0;
   logic [NOW_W-1:0]    ms_clock = '0;
   logic [DBAND_W-1:0]  dband_now = DBAND_RESET;

   mux_pot_scanner_deadband #(.CHANNEL_COUNT(CHANNELS)) dut (.*);

   mpsd_scoreboard #(.CHANNEL_COUNT(CHANNELS)) scan_check (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

   // receiver side
   initial begin
      forever begin
         @(negedge clock);
         if (hold_rx) begin
            rsp_ready <= 1'b0;
            repeat (40) @(negedge clock);
            hold_rx = 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   task automatic write_reg(input reg_sel_type which, input logic [PDATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {which, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic send_scan(input logic [NOW_W-1:0] now, input logic acc, input logic done,
                            input logic [SAMPLE_W-1:0] raw, input logic [CHAN_W-1:0] q);
      req_valid           <= 1'b1;
      req_now_ms          <= now;
      req_start_accepted  <= acc;
      req_conversion_done <= done;
      req_sample_raw      <= raw;
      req_query_channel   <= q;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      items_sent++;
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
   endtask

   task automatic drain_reports();
      req_valid <= 1'b0;
      wait (reports_waiting == 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic random_scan();
      logic [SAMPLE_W-1:0] raw;
      logic [SAMPLE_W-1:0] off;
      int                  r;
      r = $urandom_range(99);
      if (r < 85) ms_clock += $urandom_range(3);
      else if (r < 95) ms_clock += $urandom_range(300);
      else ms_clock = $urandom;
      r = $urandom_range(99);
      if (r < 45) begin
         // samples clustered around the deadband threshold
         case ($urandom_range(4))
            0: off = '0;
            1: off = 16'd1;
            2: off = dband_now - 1'b1;
            3: off = dband_now;
            default: off = dband_now + 1'b1;
         endcase
         raw = 16'h8000 + off;
      end else if (r < 60) begin
         raw = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      end else begin
         raw = SAMPLE_W'($urandom);
      end
      send_scan(ms_clock, $urandom_range(99) < 75, $urandom_range(99) < 65, raw,
                CHAN_W'($urandom_range(7)));
   endtask

   initial begin
      logic [SETTLE_W-1:0] settle_pick;
      logic [DBAND_W-1:0]  dband_pick;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_idle = 24;
      recv_idle = 63;

      // directed walk through every phase with default settings
      send_scan(32'hFFFF_FFFF, 1'b0, 1'b0, 16'h0000, 3'd7);
      send_scan(32'hFFFF_FFFF, 1'b1, 1'b1, 16'hFFFF, 3'd6);
      send_scan(32'h0000_0000, 1'b0, 1'b0, 16'h0000, 3'd0);
      send_scan(32'h0000_0000, 1'b1, 1'b0, 16'h0000, 3'd0);
      send_scan(32'd5, 1'b1, 1'b0, 16'h1234, 3'd0);
      send_scan(32'd6, 1'b0, 1'b1, 16'h0000, 3'd0);
      send_scan(32'd7, 1'b0, 1'b0, 16'h0000, 3'd0);
      send_scan(32'd9, 1'b1, 1'b0, 16'h0000, 3'd0);
      send_scan(32'd9, 1'b1, 1'b1, 16'h0000, 3'd0);
      send_scan(32'd10, 1'b0, 1'b0, 16'h0000, 3'd0);
      send_scan(32'd11, 1'b0, 1'b1, 16'h0000, 3'd0);
      send_scan(32'd12, 1'b0, 1'b0, 16'h0000, 3'd0);
      send_scan(32'd13, 1'b1, 1'b0, 16'h0000, 3'd1);
      send_scan(32'd13, 1'b1, 1'b1, 16'h0000, 3'd1);
      send_scan(32'd14, 1'b0, 1'b1, 16'hFFFF, 3'd1);
      send_scan(32'hAAAA_5555, 1'b1, 1'b1, 16'hA5A5, 3'd5);
      send_scan(32'h5555_AAAA, 1'b1, 1'b1, 16'h5A5A, 3'd2);
      drain_reports();
      ms_clock = 32'h5555_AAAA;

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin settle_pick = 8'd0;   dband_pick = 16'd0;     end
            1: begin settle_pick = 8'd255; dband_pick = 16'hFFFF;  end
            2: begin settle_pick = 8'd1;   dband_pick = 16'd768;   end
            4: begin settle_pick = 8'd3;   dband_pick = 16'd1;     end
            default: begin
               settle_pick = SETTLE_W'($urandom);
               dband_pick  = DBAND_W'($urandom);
            end
         endcase
         if (ph < 2) begin
            send_idle = 24;
            recv_idle = 63;
         end else if (ph < 4) begin
            send_idle = 63;
            recv_idle = 24;
         end else begin
            send_idle = 0;
            recv_idle = 0;
         end
         write_reg(REG_SETTLE_TIME, {24'h0, settle_pick});
         write_reg(REG_DEADBAND, {16'h0, dband_pick});
         dband_now = dband_pick;
         if (ph == 2) ms_clock = 32'hFFFF_FF80;
         if (ph == 4) hold_rx = 1'b1;
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            random_scan();
            if (ph == 5 && i == ITEMS_PER_PHASE / 2) drain_reports();
         end
         drain_reports();
      end

      repeat (10) @(posedge clock);
      $display("summary: %0d scan items over %0d register settings, with sender gaps,",
               items_sent, PHASES + 1);
      $display("summary: receiver stalls, a long output hold and timer wrap exercised");
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
